>>> hw/rtl/apbg_pkg.sv
// Shared types and constants of the audio playout buffer with gain.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package apbg_pkg;

    // Ring, rate matching and level meter sizing.
    localparam int BUF_SAMPLES    = 1024;
    localparam int PACKET_SAMPLES = 32;
    localparam int PACKET_COUNT   = 4;
    localparam int UPDATE_TICKS   = 1024;

    localparam int IDX_W  = $clog2(BUF_SAMPLES);
    localparam int PH_W   = $clog2(UPDATE_TICKS);
    localparam int THRESH = PACKET_COUNT * PACKET_SAMPLES;

    // Field widths.
    localparam int SAMPLE_W = 16;
    localparam int ADC_W    = 16;
    localparam int DAC_W    = 16;
    localparam int FILL_W   = 10;
    localparam int VU_W     = 3;
    localparam int VOL_W    = 9;
    localparam int POT_W    = 9;
    localparam int GAIN_W   = 17;
    localparam int SUM_W    = 32;
    localparam int MAG_W    = SAMPLE_W + 1;

    localparam logic [DAC_W-1:0] DAC_MID  = 16'h8000;
    localparam logic [DAC_W-1:0] DAC_MASK = 16'hFFC0;
    localparam logic [VOL_W-1:0] VOL_RESET = 9'd256;

    // Queue between the front and back parts.
    localparam int Q_DEPTH = 4;
    localparam int QP_W    = $clog2(Q_DEPTH);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    // Item kinds.
    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Configuration register map.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_STREAM_RUN  = 2'd0;
    localparam t_reg_idx REG_MUTE        = 2'd1;
    localparam t_reg_idx REG_HOST_VOLUME = 2'd2;
    localparam t_reg_idx REG_HOST_SILENT = 2'd3;

    // One tick as the front part hands it to the back part.
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [FILL_W-1:0]   fill;
        logic                update;
        logic                run;
        logic [POT_W-1:0]    pot;
    } t_tick;

    // Pot value taken from the ADC data word, 0 to 256.
    function automatic logic [POT_W-1:0] pot_from_adc(input logic [ADC_W-1:0] adc);
        pot_from_adc = {1'b0, adc[15:11], 3'b000} + {5'b00000, adc[10], 3'b000};
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/apbg_if.sv
// Valid/ready channel interfaces of the audio playout buffer: input items and results.
// Depends on apbg_pkg for field widths.
`default_nettype none

interface apbg_in_if
    import apbg_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample;
    logic [ADC_W-1:0]           adc_word;

    modport source (output valid, kind, sample, adc_word, input ready);
    modport sink   (input valid, kind, sample, adc_word, output ready);
endinterface

interface apbg_out_if
    import apbg_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DAC_W-1:0]  dac_code;
    logic              vu_valid;
    logic [VU_W-1:0]   vu_level;
    logic [FILL_W-1:0] fill_count;

    modport source (output valid, dac_code, vu_valid, vu_level, fill_count, input ready);
    modport sink   (input valid, dac_code, vu_valid, vu_level, fill_count, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/apbg_queue.sv
// Short queue of tick records between the front and back parts.
// Depends on apbg_pkg for t_tick and the queue depth.
`default_nettype none

module apbg_queue
    import apbg_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire t_tick         i_push_entry,
    input  wire logic          i_pop,
    output logic               o_head_valid,
    output t_tick              o_head,
    output logic [QC_W-1:0]    o_count
);

    t_tick           r_slot [Q_DEPTH];
    logic [QP_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QP_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QC_W-1:0] r_count, n_count;
    logic            do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_entry;
        end
    end

    assign o_head_valid = (r_count != '0);
    assign o_head       = r_slot[r_rd_ptr];
    assign o_count      = r_count;

endmodule

`default_nettype wire

>>> hw/rtl/apbg_front.sv
// Front part: accepts items, keeps the sample ring and its indexes, reads the
// sample for each tick and queues a tick record. Depends on apbg_pkg, apbg_if.
`default_nettype none

module apbg_front
    import apbg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    apbg_in_if.sink          i_in,
    input  wire logic        i_stream_run,
    input  wire logic [QC_W-1:0] i_q_count,
    output logic             o_push,
    output t_tick            o_push_entry
);

    logic [SAMPLE_W-1:0] r_mem [BUF_SAMPLES];
    logic [SAMPLE_W-1:0] r_rdata;

    logic [IDX_W-1:0] r_wr_idx, n_wr_idx;
    logic [IDX_W-1:0] r_rd_idx, n_rd_idx;
    logic [PH_W-1:0]  r_phase, n_phase;
    logic             r_wrapped, n_wrapped;

    // Tick in flight through the memory read.
    logic              r_s1_valid;
    logic              r_s1_hit;
    logic [FILL_W-1:0] r_s1_fill;
    logic              r_s1_update;
    logic              r_s1_run;
    logic [POT_W-1:0]  r_s1_pot;

    logic             accept, acc_store, acc_tick;
    logic [IDX_W-1:0] fill;
    logic [IDX_W:0]   rd_sum;
    logic [1:0]       rd_step;

    // Room is counted with the tick still in the read stage.
    assign i_in.ready = ({1'b0, i_q_count} + {{QC_W{1'b0}}, r_s1_valid})
                        < (QC_W+1)'(Q_DEPTH);
    assign accept    = i_in.valid && i_in.ready;
    assign acc_store = accept && (i_in.kind == KIND_STORE);
    assign acc_tick  = accept && (i_in.kind == KIND_TICK);

    always_comb begin
        if (r_wr_idx >= r_rd_idx) begin
            fill = r_wr_idx - r_rd_idx;
        end else begin
            fill = IDX_W'(({1'b0, r_wr_idx} + (IDX_W+1)'(BUF_SAMPLES)) - {1'b0, r_rd_idx});
        end
        rd_step = {1'b0, fill == IDX_W'(BUF_SAMPLES - THRESH)}
                + {1'b0, fill > IDX_W'(THRESH)};
        rd_sum  = {1'b0, r_rd_idx} + (IDX_W+1)'(rd_step);
    end

    always_comb begin
        n_wr_idx  = r_wr_idx;
        n_wrapped = r_wrapped;
        n_rd_idx  = r_rd_idx;
        n_phase   = r_phase;
        if (acc_store) begin
            if (r_wr_idx == IDX_W'(BUF_SAMPLES - 1)) begin
                n_wr_idx  = '0;
                n_wrapped = 1'b1;
            end else begin
                n_wr_idx = r_wr_idx + 1'b1;
            end
        end
        if (acc_tick) begin
            if (i_stream_run) begin
                if (rd_sum >= (IDX_W+1)'(BUF_SAMPLES)) begin
                    n_rd_idx = IDX_W'(rd_sum - (IDX_W+1)'(BUF_SAMPLES));
                end else begin
                    n_rd_idx = IDX_W'(rd_sum);
                end
            end
            n_phase = (r_phase == PH_W'(UPDATE_TICKS - 1)) ? '0 : r_phase + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx   <= '0;
            r_rd_idx   <= '0;
            r_phase    <= '0;
            r_wrapped  <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_wr_idx   <= n_wr_idx;
            r_rd_idx   <= n_rd_idx;
            r_phase    <= n_phase;
            r_wrapped  <= n_wrapped;
            r_s1_valid <= acc_tick;
        end
    end

    // An entry holds a sample only once the write index has passed it since
    // reset; anything else reads as the cleared value.
    always_ff @(posedge i_clk) begin
        if (acc_tick) begin
            r_s1_hit    <= r_wrapped || (r_rd_idx < r_wr_idx);
            r_s1_fill   <= FILL_W'(fill);
            r_s1_update <= (r_phase == '0);
            r_s1_run    <= i_stream_run;
            r_s1_pot    <= pot_from_adc(i_in.adc_word);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_store) begin
            r_mem[r_wr_idx] <= i_in.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_tick) begin
            r_rdata <= r_mem[r_rd_idx];
        end
    end

    assign o_push              = r_s1_valid;
    assign o_push_entry.sample = r_s1_hit ? r_rdata : '0;
    assign o_push_entry.fill   = r_s1_fill;
    assign o_push_entry.update = r_s1_update;
    assign o_push_entry.run    = r_s1_run;
    assign o_push_entry.pot    = r_s1_pot;

endmodule

`default_nettype wire

>>> hw/rtl/apbg_back.sv
// Back part: applies the gain, keeps the level sum and gain, and drives results.
// Depends on apbg_pkg for t_tick and constants, and on apbg_if.
`default_nettype none

module apbg_back
    import apbg_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_head_valid,
    input  wire t_tick            i_head,
    output logic                  o_pop,
    input  wire logic             i_mute,
    input  wire logic [VOL_W-1:0] i_host_volume,
    input  wire logic             i_host_silent,
    apbg_out_if.source            o_out
);

    logic [GAIN_W-1:0] r_gain, n_gain;
    logic [SUM_W-1:0]  r_level_sum, n_level_sum;

    // Multiply stage.
    logic              r_x_valid;
    logic [DAC_W-1:0]  r_x_prod_hi;
    logic              r_x_drive;
    logic              r_x_vu_valid;
    logic [VU_W-1:0]   r_x_vu_level;
    logic [FILL_W-1:0] r_x_fill;

    // Output register.
    logic              r_o_valid;
    logic [DAC_W-1:0]  r_o_dac;
    logic              r_o_vu_valid;
    logic [VU_W-1:0]   r_o_vu_level;
    logic [FILL_W-1:0] r_o_fill;

    logic                     x_adv, pop;
    logic [MAG_W-1:0]         mag;
    logic [SUM_W-1:0]         sum_new;
    logic [VU_W-1:0]          vu_new;
    logic signed [SAMPLE_W+GAIN_W:0] prod;
    logic [VOL_W+POT_W-1:0]   vol_pot;

    assign x_adv = r_x_valid && (!r_o_valid || o_out.ready);
    assign pop   = i_head_valid && (!r_x_valid || x_adv);
    assign o_pop = pop;

    always_comb begin
        if (i_head.sample[SAMPLE_W-1]) begin
            mag = MAG_W'(0) - {1'b1, i_head.sample};
        end else begin
            mag = {1'b0, i_head.sample};
        end
        sum_new = r_level_sum + (i_head.run ? SUM_W'(mag) : '0);
        vu_new  = (|sum_new[SUM_W-1:23]) ? '1 : sum_new[22:20];
        prod    = $signed(i_head.sample) * $signed({1'b0, r_gain});
        vol_pot = i_host_volume * i_head.pot;

        n_gain      = r_gain;
        n_level_sum = r_level_sum;
        if (pop) begin
            // The reloaded gain takes effect from the following tick.
            if (i_head.update) begin
                n_gain      = i_host_silent ? '0 : GAIN_W'(vol_pot);
                n_level_sum = '0;
            end else begin
                n_level_sum = sum_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= '0;
            r_level_sum <= '0;
            r_x_valid   <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_gain      <= n_gain;
            r_level_sum <= n_level_sum;
            if (pop) begin
                r_x_valid <= 1'b1;
            end else if (x_adv) begin
                r_x_valid <= 1'b0;
            end
            if (x_adv) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_x_prod_hi  <= prod[31:16];
            r_x_drive    <= i_head.run && !i_mute;
            r_x_vu_valid <= i_head.update;
            r_x_vu_level <= i_head.update ? vu_new : '0;
            r_x_fill     <= i_head.fill;
        end
    end

    // Adding the midpoint offset flips the top bit of the product.
    always_ff @(posedge i_clk) begin
        if (x_adv) begin
            r_o_dac      <= r_x_drive ? ((r_x_prod_hi ^ DAC_MID) & DAC_MASK)
                                      : (DAC_MID & DAC_MASK);
            r_o_vu_valid <= r_x_vu_valid;
            r_o_vu_level <= r_x_vu_level;
            r_o_fill     <= r_x_fill;
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.dac_code   = r_o_dac;
    assign o_out.vu_valid   = r_o_vu_valid;
    assign o_out.vu_level   = r_o_vu_level;
    assign o_out.fill_count = r_o_fill;

endmodule

`default_nettype wire

>>> hw/rtl/audio_playout_buffer_with_gain.sv
// Top level of the audio playout buffer with gain: configuration registers and
// the front part, tick queue and back part. Depends on apbg_pkg, apbg_if and submodules.
`default_nettype none

// The block takes one item per clock cycle, stores and ticks alike, as long as
// the result side keeps up; the single ring memory port, used once per item,
// sets that rate. A tick's result passes the ring read at the edge that accepts
// the tick, then the queue, the multiplier stage and the output register, before
// it is valid on the output.
// A store writes the ring and gives no result; every tick gives one result.
// A four-entry queue between the ring and the gain stage, plus the multiplier
// stage and an output register, keeps input acceptance going while a result
// waits, until six ticks are held inside; after that, stores stall as well.
// The ring needs no clearing pass after reset: entries the write index has not
// yet reached since reset read as zero. Configuration registers sit on the APB
// port at byte addresses 0, 4, 8 and 12 and should be written only while idle.

module audio_playout_buffer_with_gain
    import apbg_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    apbg_in_if.sink                 i_in,
    apbg_out_if.source              o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    logic             r_stream_run;
    logic             r_mute;
    logic [VOL_W-1:0] r_host_volume;
    logic             r_host_silent;

    logic      cfg_wr;
    t_reg_idx  cfg_idx;

    logic            q_push, q_pop, q_head_valid;
    t_tick           q_push_entry, q_head;
    logic [QC_W-1:0] q_count;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_run  <= 1'b0;
            r_mute        <= 1'b0;
            r_host_volume <= VOL_RESET;
            r_host_silent <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_STREAM_RUN:  r_stream_run  <= pwdata[0];
                REG_MUTE:        r_mute        <= pwdata[0];
                REG_HOST_VOLUME: r_host_volume <= pwdata[VOL_W-1:0];
                REG_HOST_SILENT: r_host_silent <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_STREAM_RUN:  prdata = PDATA_W'(r_stream_run);
            REG_MUTE:        prdata = PDATA_W'(r_mute);
            REG_HOST_VOLUME: prdata = PDATA_W'(r_host_volume);
            REG_HOST_SILENT: prdata = PDATA_W'(r_host_silent);
            default:         prdata = '0;
        endcase
    end

    apbg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_stream_run (r_stream_run),
        .i_q_count    (q_count),
        .o_push       (q_push),
        .o_push_entry (q_push_entry)
    );

    apbg_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_push_entry (q_push_entry),
        .i_pop        (q_pop),
        .o_head_valid (q_head_valid),
        .o_head       (q_head),
        .o_count      (q_count)
    );

    apbg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (q_head_valid),
        .i_head        (q_head),
        .o_pop         (q_pop),
        .i_mute        (r_mute),
        .i_host_volume (r_host_volume),
        .i_host_silent (r_host_silent),
        .o_out         (o_out)
    );

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of audio_playout_buffer_with_gain: store and tick items, APB setup
// and read-back, and a scoreboard class that predicts DAC code, VU level and fill count.
// Depends on apbg_pkg, the apbg_in_if / apbg_out_if interfaces and the block's RTL.

import apbg_pkg::*;

typedef struct {
    logic [DAC_W-1:0]  dac_code;
    logic              vu_valid;
    logic [VU_W-1:0]   vu_level;
    logic [FILL_W-1:0] fill_count;
} t_playout_result;

class playout_scoreboard;
    logic [SAMPLE_W-1:0] ring [BUF_SAMPLES];
    logic [IDX_W-1:0]    rd_idx;
    logic [IDX_W-1:0]    wr_idx;
    logic [SUM_W-1:0]    level_sum;
    logic [PH_W-1:0]     phase;
    logic [GAIN_W-1:0]   gain;
    logic                run_en;
    logic                mute_en;
    logic                silent_en;
    logic [VOL_W-1:0]    volume;
    t_playout_result     pending_results[$];
    int                  errors;

    function new();
        foreach (ring[i]) ring[i] = '0;
        rd_idx       = '0;
        wr_idx       = '0;
        level_sum    = '0;
        phase        = '0;
        gain         = '0;
        run_en       = 1'b0;
        mute_en      = 1'b0;
        silent_en    = 1'b0;
        volume       = VOL_RESET;
        errors       = 0;
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 40) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    function logic [IDX_W-1:0] buffered();
        return wr_idx - rd_idx;
    endfunction

    function void set_reg(t_reg_idx idx, logic [PDATA_W-1:0] data);
        case (idx)
            REG_STREAM_RUN:  run_en    = data[0];
            REG_MUTE:        mute_en   = data[0];
            REG_HOST_VOLUME: volume    = data[VOL_W-1:0];
            REG_HOST_SILENT: silent_en = data[0];
            default: ;
        endcase
    endfunction

    function logic [PDATA_W-1:0] reg_value(t_reg_idx idx);
        case (idx)
            REG_STREAM_RUN:  return PDATA_W'(run_en);
            REG_MUTE:        return PDATA_W'(mute_en);
            REG_HOST_VOLUME: return PDATA_W'(volume);
            default:         return PDATA_W'(silent_en);
        endcase
    endfunction

    // Called for every accepted item; a tick queues the result it will cause.
    function void note_input(logic kind, logic [SAMPLE_W-1:0] smp, logic [ADC_W-1:0] adc);
        t_playout_result    r;
        logic signed [15:0] s;
        logic [IDX_W-1:0]   nxt;
        longint             prod;
        logic [POT_W-1:0]   pot;
        logic [SUM_W-1:0]   lv;
        if (kind == KIND_STORE) begin
            ring[wr_idx] = smp;
            wr_idx = wr_idx + 1'b1;
            return;
        end
        r.fill_count = wr_idx - rd_idx;
        r.dac_code   = DAC_MID;
        r.vu_valid   = 1'b0;
        r.vu_level   = '0;
        if (run_en) begin
            s   = ring[rd_idx];
            nxt = rd_idx;
            // Skip one extra sample above THRESH buffered, and another at exactly BUF_SAMPLES - THRESH.
            if (r.fill_count == IDX_W'(BUF_SAMPLES - THRESH)) nxt = nxt + 1'b1;
            if (r.fill_count > THRESH) nxt = nxt + 1'b1;
            rd_idx    = nxt;
            level_sum = level_sum + SUM_W'((s < 0) ? -longint'(s) : longint'(s));
            prod       = longint'(s) * longint'(gain);
            r.dac_code = DAC_W'(prod >>> 16) + DAC_MID;
        end
        if (mute_en) r.dac_code = DAC_MID;
        r.dac_code = r.dac_code & DAC_MASK;
        if (phase == 0) begin
            pot  = POT_W'((adc >> 8) & 16'h00F8) + POT_W'((adc >> 7) & 16'h0008);
            gain = silent_en ? '0 : (GAIN_W'(volume) * GAIN_W'(pot));
            lv   = level_sum >> 20;
            r.vu_level = (lv > 7) ? 3'd7 : lv[VU_W-1:0];
            r.vu_valid = 1'b1;
            level_sum  = '0;
        end
        phase = phase + 1'b1;
        pending_results.push_back(r);
    endfunction

    task check_output(t_playout_result got);
        t_playout_result want;
        if (pending_results.size() == 0) begin
            report($sformatf("result with no tick pending, dac_code %h", got.dac_code));
            return;
        end
        want = pending_results.pop_front();
        if (got.dac_code !== want.dac_code)
            report($sformatf("dac_code %h, expected %h", got.dac_code, want.dac_code));
        if (got.vu_valid !== want.vu_valid)
            report($sformatf("vu_valid %b, expected %b", got.vu_valid, want.vu_valid));
        if (got.vu_level !== want.vu_level)
            report($sformatf("vu_level %0d, expected %0d", got.vu_level, want.vu_level));
        if (got.fill_count !== want.fill_count)
            report($sformatf("fill_count %0d, expected %0d", got.fill_count, want.fill_count));
    endtask
endclass

module testbench;
    localparam int MAX_WAIT     = 16;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_ITEMS = 650;
    localparam int ITEM_CEILING = 9000;

    typedef enum {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} t_idle_style;
    typedef enum {MIX_STEADY, MIX_OVERFULL, MIX_OVERRUN, MIX_NOISE} t_mix;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    t_idle_style        send_style;
    t_idle_style        take_style;
    playout_scoreboard  sb;

    apbg_in_if  in_ch();
    apbg_out_if out_ch();

    audio_playout_buffer_with_gain dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int draw_wait(t_idle_style style);
        case (style)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(0, MAX_WAIT);
            default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] draw_sample(int amp);
        logic signed [SAMPLE_W-1:0] s;
        s = SAMPLE_W'($urandom);
        case ($urandom_range(0, 31))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'hFFFF;
            3: return 16'h0001;
            4: return 16'h0000;
            default: return s >>> amp;
        endcase
    endfunction

    function automatic logic [ADC_W-1:0] draw_adc();
        case ($urandom_range(0, 7))
            0: return 16'hFFFF;
            1: return 16'h0000;
            2: return 16'h0400;
            3: return 16'hF800;
            default: return ADC_W'($urandom);
        endcase
    endfunction

    // Starts and ends at a falling edge; valid stays high for a following item.
    task automatic send_item(logic kind, logic [SAMPLE_W-1:0] smp, logic [ADC_W-1:0] adc);
        int gap;
        gap = draw_wait(send_style);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.kind     <= kind;
        in_ch.sample   <= smp;
        in_ch.adc_word <= adc;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note_input(kind, smp, adc);
        @(negedge i_clk);
    endtask

    // Stores give no result, so a drain wait after the last result lets any in flight settle.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_access(t_reg_idx idx, logic wr, logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        @(negedge i_clk);
    endtask

    task automatic check_register(t_reg_idx idx);
        logic [PDATA_W-1:0] rdata;
        apb_access(idx, 1'b0, '0, rdata);
        if (rdata !== sb.reg_value(idx))
            sb.report($sformatf("register %0d reads %h, expected %h", idx, rdata,
                                sb.reg_value(idx)));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_register(t_reg_idx idx, logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] rdata;
        apb_access(idx, 1'b1, value, rdata);
        sb.set_reg(idx, value);
        check_register(idx);
    endtask

    // Bits above each field are filled with noise; the block must ignore them.
    task automatic configure(logic run, logic mute, logic [VOL_W-1:0] vol, logic silent);
        set_register(REG_STREAM_RUN,  ($urandom & ~32'h1) | run);
        set_register(REG_MUTE,        ($urandom & ~32'h1) | mute);
        set_register(REG_HOST_VOLUME, ($urandom & ~32'h1FF) | vol);
        set_register(REG_HOST_SILENT, ($urandom & ~32'h1) | silent);
    endtask

    initial begin : result_taker
        int              stall;
        t_playout_result got;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = draw_wait(take_style);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
            got.dac_code   = out_ch.dac_code;
            got.vu_valid   = out_ch.vu_valid;
            got.vu_level   = out_ch.vu_level;
            got.fill_count = out_ch.fill_count;
            sb.check_output(got);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int               random_items;
        int               chunk;
        int               chunk_len;
        int               n;
        int               amp;
        int               burst;
        logic             burst_tick;
        logic             kind;
        logic             run;
        logic [VOL_W-1:0] vol;
        logic [IDX_W-1:0] fill;
        t_mix             mix;

        sb             = new();
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_ch.valid    = 1'b0;
        in_ch.kind     = KIND_STORE;
        in_ch.sample   = '0;
        in_ch.adc_word = '0;
        send_style     = IDLE_NONE;
        take_style     = IDLE_NONE;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        check_register(REG_STREAM_RUN);
        check_register(REG_MUTE);
        check_register(REG_HOST_VOLUME);
        check_register(REG_HOST_SILENT);

        // The first tick is an update tick; full-scale pot gives the largest gain at this volume.
        configure(1'b1, 1'b0, 9'd256, 1'b0);
        send_item(KIND_TICK, SAMPLE_W'($urandom), 16'hFFFF);
        send_item(KIND_STORE, 16'h7FFF, ADC_W'($urandom));
        send_item(KIND_STORE, 16'h8000, ADC_W'($urandom));
        send_item(KIND_STORE, 16'hFFFF, ADC_W'($urandom));
        send_item(KIND_STORE, 16'h0001, ADC_W'($urandom));
        send_item(KIND_STORE, 16'h0000, ADC_W'($urandom));
        send_item(KIND_TICK, SAMPLE_W'($urandom), ADC_W'($urandom));
        send_item(KIND_TICK, SAMPLE_W'($urandom), ADC_W'($urandom));
        wait_idle();
        configure(1'b1, 1'b1, 9'd256, 1'b0);
        send_item(KIND_TICK, SAMPLE_W'($urandom), ADC_W'($urandom));
        send_item(KIND_STORE, 16'h8000, ADC_W'($urandom));
        send_item(KIND_TICK, SAMPLE_W'($urandom), ADC_W'($urandom));
        wait_idle();
        configure(1'b0, 1'b0, 9'h1FF, 1'b1);
        send_item(KIND_TICK, SAMPLE_W'($urandom), ADC_W'($urandom));
        send_item(KIND_STORE, SAMPLE_W'($urandom), ADC_W'($urandom));
        send_item(KIND_TICK, SAMPLE_W'($urandom), ADC_W'($urandom));

        // Random chunks, each under its own settings; the first three hold the ring near
        // its hold level, walk it up to the nearly-full point and then send stores only.
        random_items = 0;
        chunk        = 0;
        while ((random_items < RANDOM_ITEMS || chunk < 3)
               && random_items < ITEM_CEILING) begin
            wait_idle();
            case (chunk)
                0:       mix = MIX_STEADY;
                1:       mix = MIX_OVERFULL;
                2:       mix = MIX_OVERRUN;
                default: mix = t_mix'($urandom_range(0, 3));
            endcase
            run = (chunk < 2) ? 1'b1 : ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 6))
                0:       vol = 9'd0;
                1:       vol = 9'd1;
                2:       vol = 9'd256;
                3:       vol = 9'h1FF;
                4:       vol = 9'd255;
                default: vol = VOL_W'($urandom_range(0, 256));
            endcase
            configure(run, $urandom_range(0, 3) == 0, vol, $urandom_range(0, 5) == 0);
            send_style = t_idle_style'($urandom_range(0, 2));
            take_style = t_idle_style'($urandom_range(0, 2));
            amp        = $urandom_range(0, 10);
            chunk_len  = (mix == MIX_OVERFULL) ? BUF_SAMPLES : $urandom_range(100, 200);
            burst      = 0;
            burst_tick = 1'b0;
            n          = 0;
            while (n < chunk_len) begin
                fill = sb.buffered();
                case (mix)
                    MIX_STEADY: begin
                        // Packets of stores against runs of ticks around the hold level.
                        if (burst == 0) begin
                            burst_tick = (fill >= 160) ? ($urandom_range(0, 3) != 0)
                                                       : ($urandom_range(0, 7) == 0);
                            burst = burst_tick ? $urandom_range(1, 48) : PACKET_SAMPLES;
                        end
                        kind = burst_tick ? KIND_TICK : KIND_STORE;
                        burst--;
                    end
                    MIX_OVERFULL: begin
                        kind = (fill < BUF_SAMPLES - THRESH) ? KIND_STORE : KIND_TICK;
                        if ($urandom_range(0, 7) == 0) kind = ~kind;
                    end
                    MIX_OVERRUN: kind = KIND_STORE;
                    default:     kind = 1'($urandom_range(0, 1));
                endcase
                send_item(kind, draw_sample(amp), draw_adc());
                n++;
            end
            random_items += n;
            chunk++;
        end

        wait_idle();
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/apbg_pkg.sv
hw/rtl/apbg_if.sv
hw/rtl/apbg_queue.sv
hw/rtl/apbg_front.sv
hw/rtl/apbg_back.sv
hw/rtl/audio_playout_buffer_with_gain.sv
verif/testbench.sv
